// ===== src/aabbrv_pkg.sv =====
// shared types and constants for the rotated-vertex bounding box block
`default_nettype none

package aabbrv_pkg;

	localparam int unsigned ROT_BITS = 16;
	localparam int unsigned ROT_FRAC = 14;
	localparam int unsigned CALC_LIMIT = 44;
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_PTR_BITS = 2;
	localparam logic signed [ROT_BITS-1:0] ROT_W_RESET = 16'sd16384;

	typedef enum logic [2:0] {
		REG_ROT_W = 3'd0,
		REG_ROT_X = 3'd1,
		REG_ROT_Y = 3'd2,
		REG_ROT_Z = 3'd3,
		REG_POS_X = 3'd4,
		REG_POS_Y = 3'd5,
		REG_POS_Z = 3'd6
	} reg_index_t;

	typedef logic signed [ROT_BITS-1:0] rot_comp_t;

	typedef struct packed {
		rot_comp_t w;
		rot_comp_t x;
		rot_comp_t y;
		rot_comp_t z;
	} quat_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

// ===== src/aabbrv_fifo.sv =====
// short vertex queue between the front and the back
`default_nettype none

module aabbrv_fifo import aabbrv_pkg::*; #(
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output q_status_t        status
);

	logic [WIDTH-1:0]         mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_ptr_q;
	logic [FIFO_PTR_BITS-1:0] rd_ptr_q;
	logic [FIFO_PTR_BITS:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	assign rd_data      = mem_q[rd_ptr_q];
	assign status.full  = (count_q == (FIFO_PTR_BITS+1)'(FIFO_DEPTH));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (FIFO_PTR_BITS+1)'(FIFO_DEPTH))
		else $error("vertex queue count beyond depth");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("vertex queue popped while empty");

endmodule

`default_nettype wire

// ===== src/aabbrv_front.sv =====
// input side: takes vertex items, clamps them to the arithmetic range, feeds the queue
`default_nettype none

module aabbrv_front import aabbrv_pkg::*; #(
	parameter int unsigned COORD_BITS = 32,
	parameter int unsigned CALC_BITS  = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic signed [COORD_BITS-1:0] vert_x,
	input  logic signed [COORD_BITS-1:0] vert_y,
	input  logic signed [COORD_BITS-1:0] vert_z,
	input  logic                         last_vertex,
	input  q_status_t                    q_status,
	output logic                         q_push,
	output logic [3*CALC_BITS:0]         q_data
);

	localparam logic signed [COORD_BITS-1:0] C_HI =
		{{(COORD_BITS-CALC_BITS+1){1'b0}}, {(CALC_BITS-1){1'b1}}};
	localparam logic signed [COORD_BITS-1:0] C_LO = ~C_HI;

	function automatic logic signed [CALC_BITS-1:0] clamp_calc(
		input logic signed [COORD_BITS-1:0] v
	);
		logic signed [CALC_BITS-1:0] r;
		if (v > C_HI) begin
			r = C_HI[CALC_BITS-1:0];
		end else if (v < C_LO) begin
			r = C_LO[CALC_BITS-1:0];
		end else begin
			r = v[CALC_BITS-1:0];
		end
		return r;
	endfunction

	logic                        valid_s1_q;
	logic                        last_s1;
	logic signed [CALC_BITS-1:0] vx_s1;
	logic signed [CALC_BITS-1:0] vy_s1;
	logic signed [CALC_BITS-1:0] vz_s1;
	logic                        take;

	assign full   = valid_s1_q && q_status.full;
	assign take   = push && !full;
	assign q_push = valid_s1_q && !q_status.full;
	assign q_data = {last_s1, vz_s1, vy_s1, vx_s1};

	always_ff @(posedge clk) begin
		if (take) begin
			vx_s1   <= clamp_calc(vert_x);
			vy_s1   <= clamp_calc(vert_y);
			vz_s1   <= clamp_calc(vert_z);
			last_s1 <= last_vertex;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
		end else if (take) begin
			valid_s1_q <= 1'b1;
		end else if (q_push) begin
			valid_s1_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== src/aabbrv_back.sv =====
// back end: rotate, translate and saturate one vertex, fold it into the running box
`default_nettype none

module aabbrv_back import aabbrv_pkg::*; #(
	parameter int unsigned COORD_BITS = 32,
	parameter int unsigned CALC_BITS  = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  quat_t                        rot,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	input  logic signed [COORD_BITS-1:0] pos_z,
	input  q_status_t                    q_status,
	input  logic [3*CALC_BITS:0]         q_data,
	output logic                         q_pop,
	output logic                         empty,
	input  logic                         pop,
	output logic signed [COORD_BITS-1:0] box_min_x,
	output logic signed [COORD_BITS-1:0] box_min_y,
	output logic signed [COORD_BITS-1:0] box_min_z,
	output logic signed [COORD_BITS-1:0] box_max_x,
	output logic signed [COORD_BITS-1:0] box_max_y,
	output logic signed [COORD_BITS-1:0] box_max_z
);

	localparam int unsigned PW = CALC_BITS + ROT_BITS;   // rot * vertex
	localparam int unsigned DW = PW + 1;                 // cross product at q30
	localparam int unsigned TW = DW - ROT_FRAC;          // t at q16
	localparam int unsigned QW = TW + ROT_BITS;          // rot * t
	localparam int unsigned SW = QW + 2;                 // w*t + u
	localparam int unsigned RW = SW - (ROT_FRAC - 1);    // doubled term at q16
	localparam int unsigned WW = RW + 2;                 // v + term + pos
	localparam int unsigned EW = (WW > COORD_BITS) ? WW : COORD_BITS;
	localparam int T_RND = 1 << (ROT_FRAC - 1);
	localparam int R_RND = 1 << (ROT_FRAC - 2);

	localparam logic signed [COORD_BITS-1:0] C_HI =
		{{(COORD_BITS-CALC_BITS+1){1'b0}}, {(CALC_BITS-1){1'b1}}};
	localparam logic signed [COORD_BITS-1:0] C_LO = ~C_HI;
	localparam logic signed [EW-1:0] W_HI =
		{{(EW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [EW-1:0] W_LO = ~W_HI;
	localparam logic signed [COORD_BITS-1:0] R_HI = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [COORD_BITS-1:0] R_LO = ~R_HI;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_MUL_V  = 7'b0000010,
		ST_T      = 7'b0000100,
		ST_MUL_T  = 7'b0001000,
		ST_SUM    = 7'b0010000,
		ST_WORLD  = 7'b0100000,
		ST_FOLD   = 7'b1000000
	} seq_state_t;

	function automatic logic signed [CALC_BITS-1:0] clamp_calc(
		input logic signed [COORD_BITS-1:0] v
	);
		logic signed [CALC_BITS-1:0] r;
		if (v > C_HI) begin
			r = C_HI[CALC_BITS-1:0];
		end else if (v < C_LO) begin
			r = C_LO[CALC_BITS-1:0];
		end else begin
			r = v[CALC_BITS-1:0];
		end
		return r;
	endfunction

	seq_state_t state_q;
	seq_state_t state_d;

	logic                         last_q;
	logic signed [CALC_BITS-1:0]  v_q [3];
	logic signed [CALC_BITS-1:0]  pc_q [3];
	logic signed [PW-1:0]         pv_q [6];
	logic signed [TW-1:0]         t_q [3];
	logic signed [QW-1:0]         qp_q [9];
	logic signed [RW-1:0]         r_q [3];
	logic signed [COORD_BITS-1:0] world_q [3];
	logic signed [COORD_BITS-1:0] run_min_q [3];
	logic signed [COORD_BITS-1:0] run_max_q [3];
	logic signed [COORD_BITS-1:0] box_min_q [3];
	logic signed [COORD_BITS-1:0] box_max_q [3];
	logic                         out_valid_q;

	logic signed [DW-1:0]         t_diff [3];
	logic signed [SW-1:0]         r_sum [3];
	logic signed [EW-1:0]         w_ext [3];
	logic signed [COORD_BITS-1:0] new_min [3];
	logic signed [COORD_BITS-1:0] new_max [3];
	logic                         out_free;
	logic                         fold_go;
	logic                         emit;

	assign q_pop    = (state_q == ST_IDLE) && !q_status.empty;
	assign out_free = !out_valid_q || pop;
	assign fold_go  = (state_q == ST_FOLD) && (!last_q || out_free);
	assign emit     = fold_go && last_q;
	assign empty    = !out_valid_q;

	assign box_min_x = box_min_q[0];
	assign box_min_y = box_min_q[1];
	assign box_min_z = box_min_q[2];
	assign box_max_x = box_max_q[0];
	assign box_max_y = box_max_q[1];
	assign box_max_z = box_max_q[2];

	always_comb begin
		// t = q.xyz cross v
		t_diff[0] = DW'(pv_q[0]) - DW'(pv_q[1]);
		t_diff[1] = DW'(pv_q[2]) - DW'(pv_q[3]);
		t_diff[2] = DW'(pv_q[4]) - DW'(pv_q[5]);
		for (int a = 0; a < 3; a++) begin
			r_sum[a]   = SW'(qp_q[3*a]) + SW'(qp_q[3*a+1]) - SW'(qp_q[3*a+2]);
			w_ext[a]   = EW'(WW'(v_q[a]) + WW'(r_q[a]) + WW'(pc_q[a]));
			new_min[a] = (world_q[a] < run_min_q[a]) ? world_q[a] : run_min_q[a];
			new_max[a] = (world_q[a] > run_max_q[a]) ? world_q[a] : run_max_q[a];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (!q_status.empty) state_d = ST_MUL_V;
			ST_MUL_V: state_d = ST_T;
			ST_T:     state_d = ST_MUL_T;
			ST_MUL_T: state_d = ST_SUM;
			ST_SUM:   state_d = ST_WORLD;
			ST_WORLD: state_d = ST_FOLD;
			ST_FOLD:  if (fold_go) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (q_pop) begin
					v_q[0]  <= q_data[CALC_BITS-1:0];
					v_q[1]  <= q_data[2*CALC_BITS-1:CALC_BITS];
					v_q[2]  <= q_data[3*CALC_BITS-1:2*CALC_BITS];
					last_q  <= q_data[3*CALC_BITS];
					pc_q[0] <= clamp_calc(pos_x);
					pc_q[1] <= clamp_calc(pos_y);
					pc_q[2] <= clamp_calc(pos_z);
				end
			end
			ST_MUL_V: begin
				pv_q[0] <= $signed(rot.y) * v_q[2];
				pv_q[1] <= $signed(rot.z) * v_q[1];
				pv_q[2] <= $signed(rot.z) * v_q[0];
				pv_q[3] <= $signed(rot.x) * v_q[2];
				pv_q[4] <= $signed(rot.x) * v_q[1];
				pv_q[5] <= $signed(rot.y) * v_q[0];
			end
			ST_T: begin
				for (int a = 0; a < 3; a++) begin
					t_q[a] <= TW'((t_diff[a] + DW'(T_RND)) >>> ROT_FRAC);
				end
			end
			ST_MUL_T: begin
				// per axis: w*t, then the two terms of q.xyz cross t
				qp_q[0] <= $signed(rot.w) * t_q[0];
				qp_q[1] <= $signed(rot.y) * t_q[2];
				qp_q[2] <= $signed(rot.z) * t_q[1];
				qp_q[3] <= $signed(rot.w) * t_q[1];
				qp_q[4] <= $signed(rot.z) * t_q[0];
				qp_q[5] <= $signed(rot.x) * t_q[2];
				qp_q[6] <= $signed(rot.w) * t_q[2];
				qp_q[7] <= $signed(rot.x) * t_q[1];
				qp_q[8] <= $signed(rot.y) * t_q[0];
			end
			ST_SUM: begin
				for (int a = 0; a < 3; a++) begin
					r_q[a] <= RW'((r_sum[a] + SW'(R_RND)) >>> (ROT_FRAC - 1));
				end
			end
			ST_WORLD: begin
				for (int a = 0; a < 3; a++) begin
					if (w_ext[a] > W_HI) begin
						world_q[a] <= W_HI[COORD_BITS-1:0];
					end else if (w_ext[a] < W_LO) begin
						world_q[a] <= W_LO[COORD_BITS-1:0];
					end else begin
						world_q[a] <= w_ext[a][COORD_BITS-1:0];
					end
				end
			end
			ST_FOLD: begin
				if (emit) begin
					box_min_q <= new_min;
					box_max_q <= new_max;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			for (int a = 0; a < 3; a++) begin
				run_min_q[a] <= R_HI;
				run_max_q[a] <= R_LO;
			end
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			if (fold_go) begin
				for (int a = 0; a < 3; a++) begin
					// the last vertex of a body restarts the bounds
					run_min_q[a] <= last_q ? R_HI : new_min[a];
					run_max_q[a] <= last_q ? R_LO : new_max[a];
				end
			end
		end
	end

	a_bounds_restart: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (run_min_q[0] == R_HI && run_max_q[2] == R_LO))
		else $error("running bounds not restarted after a box");

	a_box_shown: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> !empty)
		else $error("finished box not presented");

	a_fold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FOLD && last_q && out_valid_q && !pop) |=> state_q == ST_FOLD)
		else $error("fold went on while the box slot was taken");

endmodule

`default_nettype wire

// ===== src/aabb_of_rotated_vertices.sv =====
// top level of the rotated-vertex bounding box block
`default_nettype none

// Bounding box of one body's vertices after rotation by a Q1.14 quaternion and
// translation by a Q16.16 position, both set through the cfg port; the user must write
// them only while the block is idle, which the block itself does not enforce. Vertices
// enter one item per push; the item flagged last_vertex closes the body and yields one
// box on the result side. Each vertex passes in order through the back-end sequencer
// steps (products with the vector part, rounding of the first cross product, second
// set of products, rounding of the doubled term, translate and saturate, fold into
// the running box, next fetch); the sequencer takes no new item until it is through
// with the last. An input register and a 4-entry queue take a burst of up to 5 items
// ahead of the sequencer. A finished box sits in an output register until popped; the
// sequencer waits on the next body's last vertex only if that box is still there.
module aabb_of_rotated_vertices import aabbrv_pkg::*; #(
	parameter int unsigned COORD_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [2:0]                   cfg_index,
	input  logic [COORD_BITS-1:0]        cfg_data,
	input  logic                         push,
	output logic                         full,
	input  logic signed [COORD_BITS-1:0] vert_x,
	input  logic signed [COORD_BITS-1:0] vert_y,
	input  logic signed [COORD_BITS-1:0] vert_z,
	input  logic                         last_vertex,
	output logic                         empty,
	input  logic                         pop,
	output logic signed [COORD_BITS-1:0] box_min_x,
	output logic signed [COORD_BITS-1:0] box_min_y,
	output logic signed [COORD_BITS-1:0] box_min_z,
	output logic signed [COORD_BITS-1:0] box_max_x,
	output logic signed [COORD_BITS-1:0] box_max_y,
	output logic signed [COORD_BITS-1:0] box_max_z
);

	localparam int unsigned CALC_BITS = (COORD_BITS > CALC_LIMIT) ? CALC_LIMIT : COORD_BITS;
	localparam int unsigned QW = 3 * CALC_BITS + 1;

	quat_t                        rot_q;
	logic signed [COORD_BITS-1:0] pos_x_q;
	logic signed [COORD_BITS-1:0] pos_y_q;
	logic signed [COORD_BITS-1:0] pos_z_q;

	q_status_t        q_status;
	logic             q_push;
	logic             q_pop;
	logic [QW-1:0]    q_wr_data;
	logic [QW-1:0]    q_rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q.w <= ROT_W_RESET;
			rot_q.x <= '0;
			rot_q.y <= '0;
			rot_q.z <= '0;
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_ROT_W: rot_q.w <= cfg_data[ROT_BITS-1:0];
				REG_ROT_X: rot_q.x <= cfg_data[ROT_BITS-1:0];
				REG_ROT_Y: rot_q.y <= cfg_data[ROT_BITS-1:0];
				REG_ROT_Z: rot_q.z <= cfg_data[ROT_BITS-1:0];
				REG_POS_X: pos_x_q <= cfg_data;
				REG_POS_Y: pos_y_q <= cfg_data;
				REG_POS_Z: pos_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	aabbrv_front #(
		.COORD_BITS (COORD_BITS),
		.CALC_BITS  (CALC_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.vert_x      (vert_x),
		.vert_y      (vert_y),
		.vert_z      (vert_z),
		.last_vertex (last_vertex),
		.q_status    (q_status),
		.q_push      (q_push),
		.q_data      (q_wr_data)
	);

	aabbrv_fifo #(
		.WIDTH (QW)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wr_data),
		.pop     (q_pop),
		.rd_data (q_rd_data),
		.status  (q_status)
	);

	aabbrv_back #(
		.COORD_BITS (COORD_BITS),
		.CALC_BITS  (CALC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rot       (rot_q),
		.pos_x     (pos_x_q),
		.pos_y     (pos_y_q),
		.pos_z     (pos_z_q),
		.q_status  (q_status),
		.q_data    (q_rd_data),
		.q_pop     (q_pop),
		.empty     (empty),
		.pop       (pop),
		.box_min_x (box_min_x),
		.box_min_y (box_min_y),
		.box_min_z (box_min_z),
		.box_max_x (box_max_x),
		.box_max_y (box_max_y),
		.box_max_z (box_max_z)
	);

endmodule

`default_nettype wire

// ===== tb/sv/aabb_box_checker.sv =====
// box predictor and result checker for aabb_of_rotated_vertices
module aabb_box_checker import aabbrv_pkg::*; #(
	parameter int unsigned COORD_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [2:0]                   cfg_index,
	input  logic [COORD_BITS-1:0]        cfg_data,
	input  logic                         push,
	input  logic                         full,
	input  logic signed [COORD_BITS-1:0] vert_x,
	input  logic signed [COORD_BITS-1:0] vert_y,
	input  logic signed [COORD_BITS-1:0] vert_z,
	input  logic                         last_vertex,
	input  logic                         empty,
	input  logic                         pop,
	input  logic signed [COORD_BITS-1:0] box_min_x,
	input  logic signed [COORD_BITS-1:0] box_min_y,
	input  logic signed [COORD_BITS-1:0] box_min_z,
	input  logic signed [COORD_BITS-1:0] box_max_x,
	input  logic signed [COORD_BITS-1:0] box_max_y,
	input  logic signed [COORD_BITS-1:0] box_max_z,
	output int                           fail_count,
	output int                           boxes_owed
);

	localparam int CALC_BITS = (COORD_BITS > CALC_LIMIT) ? CALC_LIMIT : COORD_BITS;

	// index 0..2 are the minima x/y/z, 3..5 the maxima
	typedef logic [5:0][COORD_BITS-1:0] box_t;

	longint rot_w, rot_x, rot_y, rot_z;
	longint pos [3];
	longint run_lo [3];
	longint run_hi [3];
	box_t   pending_boxes [$];
	int     fails;

	function automatic longint top_of(int bits);
		return (longint'(1) << (bits - 1)) - 1;
	endfunction

	function automatic longint clamp(longint v, int bits);
		longint hi = top_of(bits);
		if (v > hi)
			return hi;
		if (v < -hi - 1)
			return -hi - 1;
		return v;
	endfunction

	// round half up, then floor by 2^k
	function automatic longint round_q(longint v, int k);
		return (v + (longint'(1) << (k - 1))) >>> k;
	endfunction

	function automatic string field_name(int i);
		case (i)
			0: return "box_min_x";
			1: return "box_min_y";
			2: return "box_min_z";
			3: return "box_max_x";
			4: return "box_max_y";
			default: return "box_max_z";
		endcase
	endfunction

	function automatic void clear_bounds();
		for (int i = 0; i < 3; i++) begin
			run_lo[i] = top_of(COORD_BITS);
			run_hi[i] = -top_of(COORD_BITS) - 1;
		end
	endfunction

	// world = v + 2*(w*t + q x t) + pos with t = q x v
	function automatic void place_vertex(input longint vx, input longint vy, input longint vz,
			output longint wx, output longint wy, output longint wz);
		longint t [3];
		longint u [3];
		longint cx, cy, cz, px, py, pz;
		cx = clamp(vx, CALC_BITS);
		cy = clamp(vy, CALC_BITS);
		cz = clamp(vz, CALC_BITS);
		px = clamp(pos[0], CALC_BITS);
		py = clamp(pos[1], CALC_BITS);
		pz = clamp(pos[2], CALC_BITS);
		t[0] = round_q(rot_y * cz - rot_z * cy, ROT_FRAC);
		t[1] = round_q(rot_z * cx - rot_x * cz, ROT_FRAC);
		t[2] = round_q(rot_x * cy - rot_y * cx, ROT_FRAC);
		u[0] = rot_y * t[2] - rot_z * t[1];
		u[1] = rot_z * t[0] - rot_x * t[2];
		u[2] = rot_x * t[1] - rot_y * t[0];
		wx = clamp(cx + round_q(rot_w * t[0] + u[0], ROT_FRAC - 1) + px, COORD_BITS);
		wy = clamp(cy + round_q(rot_w * t[1] + u[1], ROT_FRAC - 1) + py, COORD_BITS);
		wz = clamp(cz + round_q(rot_w * t[2] + u[2], ROT_FRAC - 1) + pz, COORD_BITS);
	endfunction

	function automatic void fold_vertex();
		longint w [3];
		box_t b;
		place_vertex(vert_x, vert_y, vert_z, w[0], w[1], w[2]);
		for (int i = 0; i < 3; i++) begin
			if (w[i] < run_lo[i])
				run_lo[i] = w[i];
			if (w[i] > run_hi[i])
				run_hi[i] = w[i];
		end
		if (last_vertex) begin
			for (int i = 0; i < 3; i++) begin
				b[i] = run_lo[i][COORD_BITS-1:0];
				b[i+3] = run_hi[i][COORD_BITS-1:0];
			end
			pending_boxes.insert(pending_boxes.size(), b);
			clear_bounds();
		end
	endfunction

	function automatic void check_box();
		box_t got, want;
		got = {box_max_z, box_max_y, box_max_x, box_min_z, box_min_y, box_min_x};
		if (pending_boxes.size() == 0) begin
			fails++;
			if (fails <= 10)
				$display("box popped with none outstanding: min %0d %0d %0d max %0d %0d %0d",
					box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z);
		end else begin
			want = pending_boxes.pop_front();
			for (int i = 0; i < 6; i++) begin
				if (got[i] !== want[i]) begin
					fails++;
					if (fails <= 10)
						$display("%s mismatch: expected %0d actual %0d", field_name(i),
							$signed(want[i]), $signed(got[i]));
				end
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_w = longint'(ROT_W_RESET);
			rot_x = 0;
			rot_y = 0;
			rot_z = 0;
			for (int i = 0; i < 3; i++)
				pos[i] = 0;
			clear_bounds();
			pending_boxes.delete();
			fails = 0;
			fail_count <= 0;
			boxes_owed <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ROT_W: rot_w = longint'($signed(cfg_data[ROT_BITS-1:0]));
					REG_ROT_X: rot_x = longint'($signed(cfg_data[ROT_BITS-1:0]));
					REG_ROT_Y: rot_y = longint'($signed(cfg_data[ROT_BITS-1:0]));
					REG_ROT_Z: rot_z = longint'($signed(cfg_data[ROT_BITS-1:0]));
					REG_POS_X: pos[0] = longint'($signed(cfg_data));
					REG_POS_Y: pos[1] = longint'($signed(cfg_data));
					REG_POS_Z: pos[2] = longint'($signed(cfg_data));
					default: ;
				endcase
			end
			// the box on the ports now is older than any box this edge's item closes
			if (pop && !empty)
				check_box();
			if (push && !full)
				fold_vertex();
			boxes_owed <= pending_boxes.size();
			fail_count <= fails;
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
// stimulus and verdict for the aabb_of_rotated_vertices testbench
module tb;
	import aabbrv_pkg::*;

	localparam int CB = 32;
	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 64;
	localparam logic [2:0] REG_SPARE = 3'd7;

	typedef logic signed [CB-1:0] coord_t;

	localparam coord_t CMAX = {1'b0, {(CB-1){1'b1}}};
	localparam coord_t CMIN = {1'b1, {(CB-1){1'b0}}};

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          cfg_we = 1'b0;
	logic [2:0]    cfg_index = '0;
	logic [CB-1:0] cfg_data = '0;
	logic          push = 1'b0;
	logic          full;
	coord_t        vert_x = '0;
	coord_t        vert_y = '0;
	coord_t        vert_z = '0;
	logic          last_vertex = 1'b0;
	logic          empty;
	logic          pop = 1'b0;
	coord_t        box_min_x, box_min_y, box_min_z;
	coord_t        box_max_x, box_max_y, box_max_z;
	int            fail_count;
	int            boxes_owed;
	int            idle_cycles = 0;
	bit            push_steady = 1'b0;

	aabb_of_rotated_vertices #(.COORD_BITS(CB)) u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.push(push), .full(full),
		.vert_x(vert_x), .vert_y(vert_y), .vert_z(vert_z), .last_vertex(last_vertex),
		.empty(empty), .pop(pop),
		.box_min_x(box_min_x), .box_min_y(box_min_y), .box_min_z(box_min_z),
		.box_max_x(box_max_x), .box_max_y(box_max_y), .box_max_z(box_max_z)
	);

	aabb_box_checker #(.COORD_BITS(CB)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.push(push), .full(full),
		.vert_x(vert_x), .vert_y(vert_y), .vert_z(vert_z), .last_vertex(last_vertex),
		.empty(empty), .pop(pop),
		.box_min_x(box_min_x), .box_min_y(box_min_y), .box_min_z(box_min_z),
		.box_max_x(box_max_x), .box_max_y(box_max_y), .box_max_z(box_max_z),
		.fail_count(fail_count), .boxes_owed(boxes_owed)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic coord_t rand_full();
		logic [63:0] r = {$urandom(), $urandom()};
		return r[CB-1:0];
	endfunction

	function automatic coord_t rand_span(int half);
		return coord_t'(longint'($urandom_range(0, 2 * half)) - half);
	endfunction

	function automatic coord_t rand_vertex_coord();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: return CMAX;
					1: return CMIN;
					2: return '0;
					default: return -1;
				endcase
			end
			1, 2: return rand_full();
			default: return rand_span(1 << 20);
		endcase
	endfunction

	function automatic coord_t rand_position();
		case ($urandom_range(0, 7))
			0: return CMAX;
			1: return CMIN;
			2: return rand_full();
			default: return rand_span(1 << 22);
		endcase
	endfunction

	task automatic rand_quat(output rot_comp_t w, output rot_comp_t x,
			output rot_comp_t y, output rot_comp_t z);
		int axis = $urandom_range(0, 2);
		rot_comp_t part = $urandom_range(0, 1) ? 16'sd11585 : -16'sd11585;
		w = '0;
		x = '0;
		y = '0;
		z = '0;
		case ($urandom_range(0, 4))
			0: w = ROT_W_RESET;
			1: begin
				// quarter turn about one axis
				w = 16'sd11585;
				if (axis == 0) x = part;
				else if (axis == 1) y = part;
				else z = part;
			end
			2: begin
				// half turn about one axis
				if (axis == 0) x = 16'sd16384;
				else if (axis == 1) y = -16'sd16384;
				else z = 16'sd16384;
			end
			default: begin
				w = rot_comp_t'($urandom());
				x = rot_comp_t'($urandom());
				y = rot_comp_t'($urandom());
				z = rot_comp_t'($urandom());
			end
		endcase
	endtask

	function automatic logic [CB-1:0] pad_rot(rot_comp_t r);
		logic [63:0] n = {$urandom(), $urandom()};
		n[ROT_BITS-1:0] = r;
		return n[CB-1:0];
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [CB-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic set_pose(input rot_comp_t w, input rot_comp_t x, input rot_comp_t y,
			input rot_comp_t z, input coord_t px, input coord_t py, input coord_t pz);
		write_reg(REG_ROT_W, pad_rot(w));
		write_reg(REG_ROT_X, pad_rot(x));
		write_reg(REG_ROT_Y, pad_rot(y));
		write_reg(REG_ROT_Z, pad_rot(z));
		write_reg(REG_POS_X, px);
		write_reg(REG_POS_Y, py);
		write_reg(REG_POS_Z, pz);
		// a write to the unmapped index must leave the pose alone
		write_reg(REG_SPARE, rand_full());
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_vertex(input coord_t x, input coord_t y, input coord_t z,
			input logic last);
		int gap;
		if ($urandom_range(0, 9) == 0)
			push_steady = !push_steady;
		gap = push_steady ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		vert_x <= x;
		vert_y <= y;
		vert_z <= z;
		last_vertex <= last;
		do @(posedge clk); while (full);
	endtask

	task automatic wait_boxes_out();
		push <= 1'b0;
		@(posedge clk);
		while (boxes_owed != 0)
			@(posedge clk);
	endtask

	// vertices that close no box may still be in the sequencer
	task automatic settle();
		wait_boxes_out();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// receiver
	initial begin
		int stall;
		bit steady;
		steady = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if ($urandom_range(0, 9) == 0)
				steady = !steady;
			stall = steady ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || cfg_we)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("aabb_of_rotated_vertices verification failed");
				$finish;
			end
		end
	end

	initial begin
		int sent;
		int len;
		bit paused;
		rot_comp_t qw, qx, qy, qz;
		paused = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset pose: identity rotation at the origin
		send_vertex('0, '0, '0, 1'b1);
		send_vertex(CMAX, CMIN, 1, 1'b0);
		send_vertex(CMIN, CMAX, -1, 1'b0);
		send_vertex(-1, '0, CMAX, 1'b0);
		send_vertex(1, 1, CMIN, 1'b1);

		// translation pushes the far corner past the top of the range
		settle();
		set_pose(ROT_W_RESET, '0, '0, '0, CMAX, CMAX, CMAX);
		send_vertex(CMAX, CMAX, CMAX, 1'b0);
		send_vertex(CMIN, CMIN, CMIN, 1'b0);
		send_vertex(1, -1, '0, 1'b1);

		settle();
		set_pose(ROT_W_RESET, '0, '0, '0, CMIN, CMIN, CMIN);
		send_vertex(CMIN, CMIN, CMIN, 1'b0);
		send_vertex(CMAX, CMAX, CMAX, 1'b1);

		// quaternion far from unit length, all parts at their limits
		settle();
		set_pose(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, '0, '0, '0);
		send_vertex(CMAX, CMIN, CMAX, 1'b0);
		send_vertex(CMIN, CMAX, 1, 1'b0);
		send_vertex(32'sd65536, -32'sd65536, 32'sd12345, 1'b1);

		settle();
		set_pose(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
			rand_full(), rand_full(), rand_full());
		send_vertex(CMAX, CMAX, CMIN, 1'b1);
		send_vertex(-1, -1, -1, 1'b1);

		// quarter turn about z
		settle();
		set_pose(16'sd11585, '0, '0, 16'sd11585, 32'sd65536, -32'sd65536, '0);
		send_vertex(32'sd65536, '0, '0, 1'b0);
		send_vertex('0, 32'sd131072, -32'sd65536, 1'b0);
		send_vertex(-32'sd98304, 32'sd32768, 32'sd196608, 1'b1);

		for (int phase = 0; phase < 8; phase++) begin
			settle();
			rand_quat(qw, qx, qy, qz);
			set_pose(qw, qx, qy, qz, rand_position(), rand_position(), rand_position());
			sent = 0;
			while (sent < 66) begin
				len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(1, 8);
				for (int k = 0; k < len; k++) begin
					send_vertex(rand_vertex_coord(), rand_vertex_coord(), rand_vertex_coord(),
						k == len - 1);
					sent++;
				end
				if (phase == 3 && !paused && sent > 30) begin
					wait_boxes_out();
					paused = 1'b1;
				end
			end
		end

		settle();
		if (fail_count == 0)
			$display("aabb_of_rotated_vertices verification clean");
		else
			$display("aabb_of_rotated_vertices verification failed");
		$finish;
	end

endmodule
